@@ hdl/round_robin_quantum_scheduler_defines.svh @@
// assertion macros for the round-robin quantum scheduler
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define RRQS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication
`define RRQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

@@ hdl/rrqs_pkg.sv @@
// shared types and constants of the round-robin quantum scheduler
`default_nettype none
package rrqs_pkg;

    localparam int MAX_JOBS_DEFAULT = 16;
    localparam logic [7:0] QUANTUM_RESET = 8'd4;

    typedef enum logic [2:0] {
        EV_IDLE     = 3'd0,
        EV_ARRIVED  = 3'd1,
        EV_REJECTED = 3'd2,
        EV_SELECTED = 3'd3,
        EV_FINISHED = 3'd4
    } event_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_SELECT,
        ST_UPDATE,
        ST_FINISH,
        ST_CLEAR,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic do_latch;
        logic do_arrive;
        logic do_select;
        logic do_update;
        logic do_finish;
        logic do_clear;
        logic do_flush;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic finish_hit;
    } status_t;

endpackage
`default_nettype wire

@@ hdl/rrqs_ctrl.sv @@
// sequencing state machine of the scheduler
`default_nettype none
module rrqs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rrqs_pkg::status_t status,
    output rrqs_pkg::cmd_t         cmd
);

    rrqs_pkg::state_t state_reg;
    rrqs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrqs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrqs_pkg::ST_IDLE:
                if (in_valid) state_next = rrqs_pkg::ST_ARRIVE;
            rrqs_pkg::ST_ARRIVE:
                if (status.slot_free) state_next = rrqs_pkg::ST_SELECT;
            rrqs_pkg::ST_SELECT:
                if (status.slot_free) state_next = rrqs_pkg::ST_UPDATE;
            rrqs_pkg::ST_UPDATE:
                state_next = status.finish_hit ? rrqs_pkg::ST_FINISH : rrqs_pkg::ST_CLEAR;
            rrqs_pkg::ST_FINISH:
                if (status.slot_free) state_next = rrqs_pkg::ST_CLEAR;
            rrqs_pkg::ST_CLEAR:
                state_next = rrqs_pkg::ST_FLUSH;
            rrqs_pkg::ST_FLUSH:
                if (status.slot_free) state_next = rrqs_pkg::ST_IDLE;
            default:
                state_next = rrqs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            rrqs_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.do_latch = in_valid;
            end
            rrqs_pkg::ST_ARRIVE: cmd.do_arrive = status.slot_free;
            rrqs_pkg::ST_SELECT: cmd.do_select = status.slot_free;
            rrqs_pkg::ST_UPDATE: cmd.do_update = 1'b1;
            rrqs_pkg::ST_FINISH: cmd.do_finish = status.slot_free;
            rrqs_pkg::ST_CLEAR:  cmd.do_clear  = 1'b1;
            rrqs_pkg::ST_FLUSH:  cmd.do_flush  = status.slot_free;
            default:             cmd           = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/rrqs_dp.sv @@
// job table, counters and result registers of the scheduler
`default_nettype none
module rrqs_dp #(
    parameter int MAX_JOBS = rrqs_pkg::MAX_JOBS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rrqs_pkg::cmd_t cmd,
    output rrqs_pkg::status_t   status,
    input  wire logic           cfg_we,
    input  wire logic [7:0]     cfg_wdata,
    input  wire logic           arrival_valid,
    input  wire logic [7:0]     arrival_job_id,
    input  wire logic [15:0]    arrival_burst,
    input  wire logic           end_of_run,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [2:0]          event_kind,
    output logic [7:0]          event_job_id,
    output logic [15:0]         remaining_burst,
    output logic [15:0]         wait_ticks,
    output logic [15:0]         turnaround_ticks,
    output logic                last_event
);

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_JOBS);

    logic [7:0]  tq_reg;
    logic        a_valid_reg;
    logic [7:0]  a_id_reg;
    logic [15:0] a_burst_reg;
    logic        eor_reg;

    logic [7:0]  ids_reg [MAX_JOBS];
    logic [15:0] rem_reg [MAX_JOBS];
    logic [15:0] wt_reg  [MAX_JOBS];
    logic [15:0] ta_reg  [MAX_JOBS];
    logic [7:0]  ids_next [MAX_JOBS];
    logic [15:0] rem_next [MAX_JOBS];
    logic [15:0] wt_next  [MAX_JOBS];
    logic [15:0] ta_next  [MAX_JOBS];

    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          busy_reg, busy_next;
    logic [7:0]    qleft_reg, qleft_next;

    logic                  pend_valid_reg;
    rrqs_pkg::event_kind_t pend_kind_reg;
    logic [7:0]            pend_id_reg;
    logic [15:0]           pend_rem_reg, pend_wt_reg, pend_ta_reg;

    logic                  out_valid_reg;
    rrqs_pkg::event_kind_t out_kind_reg;
    logic [7:0]            out_id_reg;
    logic [15:0]           out_rem_reg, out_wt_reg, out_ta_reg;
    logic                  out_last_reg;

    logic                  emit;
    rrqs_pkg::event_kind_t e_kind;
    logic [7:0]            e_id;
    logic [15:0]           e_rem, e_wt, e_ta;
    logic                  push;

    logic [CW-1:0] idx_ext;
    logic [CW-1:0] idx_inc;
    logic [IW-1:0] sel;
    logic [15:0]   cur_rem_dec;
    logic [7:0]    qleft_dec;
    logic          run_ok;

    assign idx_ext     = CW'(idx_reg);
    assign idx_inc     = idx_ext + CW'(1);
    assign sel         = (idx_ext >= count_reg) ? '0 : idx_reg;
    assign run_ok      = busy_reg && (idx_ext < count_reg);
    assign cur_rem_dec = (rem_reg[idx_reg] != 16'd0) ? rem_reg[idx_reg] - 16'd1 : 16'd0;
    assign qleft_dec   = (qleft_reg != 8'd0) ? qleft_reg - 8'd1 : 8'd0;

    assign status.slot_free  = !out_valid_reg || out_ready;
    assign status.finish_hit = run_ok && (cur_rem_dec == 16'd0);

    always_comb
    begin
        emit       = 1'b0;
        e_kind     = rrqs_pkg::EV_IDLE;
        e_id       = 8'd0;
        e_rem      = 16'd0;
        e_wt       = 16'd0;
        e_ta       = 16'd0;
        count_next = count_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        qleft_next = qleft_reg;
        for (int j = 0; j < MAX_JOBS; j++)
        begin
            ids_next[j] = ids_reg[j];
            rem_next[j] = rem_reg[j];
            wt_next[j]  = wt_reg[j];
            ta_next[j]  = ta_reg[j];
        end

        if (cmd.do_arrive && a_valid_reg)
        begin
            emit = 1'b1;
            e_id = a_id_reg;
            if ((count_reg >= FULL) || (a_burst_reg == 16'd0))
            begin
                e_kind = rrqs_pkg::EV_REJECTED;
            end
            else
            begin
                e_kind = rrqs_pkg::EV_ARRIVED;
                ids_next[count_reg[IW-1:0]] = a_id_reg;
                rem_next[count_reg[IW-1:0]] = a_burst_reg;
                wt_next[count_reg[IW-1:0]]  = 16'd0;
                ta_next[count_reg[IW-1:0]]  = 16'd0;
                count_next = count_reg + CW'(1);
            end
        end

        if (cmd.do_select && !busy_reg)
        begin
            emit = 1'b1;
            if (count_reg != '0)
            begin
                idx_next   = sel;
                busy_next  = 1'b1;
                qleft_next = (tq_reg != 8'd0) ? tq_reg : 8'd1;
                e_kind     = rrqs_pkg::EV_SELECTED;
                e_id       = ids_reg[sel];
                e_rem      = rem_reg[sel];
            end
        end

        if (cmd.do_update)
        begin
            for (int j = 0; j < MAX_JOBS; j++)
            begin
                if (CW'(j) < count_reg)
                begin
                    if (ta_reg[j] != 16'hFFFF) ta_next[j] = ta_reg[j] + 16'd1;
                    if (!(busy_reg && (IW'(j) == idx_reg)) && (wt_reg[j] != 16'hFFFF))
                    begin
                        wt_next[j] = wt_reg[j] + 16'd1;
                    end
                end
            end
            if (run_ok)
            begin
                rem_next[idx_reg] = cur_rem_dec;
                qleft_next        = qleft_dec;
                if ((cur_rem_dec != 16'd0) && (qleft_dec == 8'd0))
                begin
                    busy_next = 1'b0;
                    idx_next  = (idx_inc >= count_reg) ? '0 : idx_inc[IW-1:0];
                end
            end
            else if (busy_reg)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
        end

        if (cmd.do_finish)
        begin
            emit   = 1'b1;
            e_kind = rrqs_pkg::EV_FINISHED;
            e_id   = ids_reg[idx_reg];
            e_wt   = wt_reg[idx_reg];
            e_ta   = ta_reg[idx_reg];
            for (int j = 0; j < MAX_JOBS - 1; j++)
            begin
                if (IW'(j) >= idx_reg)
                begin
                    ids_next[j] = ids_reg[j+1];
                    rem_next[j] = rem_reg[j+1];
                    wt_next[j]  = wt_reg[j+1];
                    ta_next[j]  = ta_reg[j+1];
                end
            end
            count_next = count_reg - CW'(1);
            busy_next  = 1'b0;
            if (idx_ext >= count_reg - CW'(1)) idx_next = '0;
        end

        if (cmd.do_clear && eor_reg)
        begin
            count_next = '0;
            idx_next   = '0;
            busy_next  = 1'b0;
            qleft_next = 8'd0;
        end
    end

    assign push = pend_valid_reg && (emit || cmd.do_flush);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tq_reg         <= rrqs_pkg::QUANTUM_RESET;
            count_reg      <= '0;
            idx_reg        <= '0;
            busy_reg       <= 1'b0;
            qleft_reg      <= 8'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we) tq_reg <= cfg_wdata;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
            qleft_reg <= qleft_next;
            if (emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.do_flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_latch)
        begin
            a_valid_reg <= arrival_valid;
            a_id_reg    <= arrival_job_id;
            a_burst_reg <= arrival_burst;
            eor_reg     <= end_of_run;
        end
        for (int j = 0; j < MAX_JOBS; j++)
        begin
            ids_reg[j] <= ids_next[j];
            rem_reg[j] <= rem_next[j];
            wt_reg[j]  <= wt_next[j];
            ta_reg[j]  <= ta_next[j];
        end
        if (emit)
        begin
            pend_kind_reg <= e_kind;
            pend_id_reg   <= e_id;
            pend_rem_reg  <= e_rem;
            pend_wt_reg   <= e_wt;
            pend_ta_reg   <= e_ta;
        end
        if (push)
        begin
            out_kind_reg <= pend_kind_reg;
            out_id_reg   <= pend_id_reg;
            out_rem_reg  <= pend_rem_reg;
            out_wt_reg   <= pend_wt_reg;
            out_ta_reg   <= pend_ta_reg;
            out_last_reg <= cmd.do_flush;
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_kind       = out_kind_reg;
    assign event_job_id     = out_id_reg;
    assign remaining_burst  = out_rem_reg;
    assign wait_ticks       = out_wt_reg;
    assign turnaround_ticks = out_ta_reg;
    assign last_event       = out_last_reg;

endmodule
`default_nettype wire

@@ hdl/round_robin_quantum_scheduler.sv @@
// top level of the round-robin quantum scheduler
// usage:
//   input channel in_valid/in_ready carries one tick per transaction: an
//   optional arriving job (arrival_valid, arrival_job_id, arrival_burst) and
//   the end_of_run flag
//   output channel out_valid/out_ready carries one event per transaction,
//   zero to three per tick, last_event set on the final one
//   cfg_we/cfg_wdata writes time_quantum (reset 4); the user must write it
//   only while idle, the block itself does not check this
// sequencing:
//   a tick is worked through by the sequencer walking arrive, select,
//   update, finish (only when a job finishes), clear and flush steps;
//   all table lanes update in parallel in the update step
//   each event is held in a pending register until the next event or the
//   flush step pushes it out, so that last_event is known
// reset:
//   table empty, cpu idle, quantum register at 4, no output pending
// stall:
//   a stalled receiver holds the sequencer at the next emitting step;
//   in_ready stays low until the tick's events are all handed off
`default_nettype none
`include "round_robin_quantum_scheduler_defines.svh"
module round_robin_quantum_scheduler #(
    parameter int MAX_JOBS = rrqs_pkg::MAX_JOBS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        arrival_valid,
    input  wire logic [7:0]  arrival_job_id,
    input  wire logic [15:0] arrival_burst,
    input  wire logic        end_of_run,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       event_kind,
    output logic [7:0]       event_job_id,
    output logic [15:0]      remaining_burst,
    output logic [15:0]      wait_ticks,
    output logic [15:0]      turnaround_ticks,
    output logic             last_event,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata
);

    rrqs_pkg::cmd_t    cmd;
    rrqs_pkg::status_t status;

    rrqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rrqs_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .arrival_valid    (arrival_valid),
        .arrival_job_id   (arrival_job_id),
        .arrival_burst    (arrival_burst),
        .end_of_run       (end_of_run),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .event_kind       (event_kind),
        .event_job_id     (event_job_id),
        .remaining_burst  (remaining_burst),
        .wait_ticks       (wait_ticks),
        .turnaround_ticks (turnaround_ticks),
        .last_event       (last_event)
    );

    `RRQS_ASSERT_NEXT(a_one_tick_at_a_time, in_valid && in_ready, !in_ready)
    `RRQS_ASSERT_NOW(a_idle_has_no_job,
        out_valid && (event_kind == rrqs_pkg::EV_IDLE), event_job_id == 8'd0)
    `RRQS_ASSERT_NOW(a_finish_no_remaining,
        out_valid && (event_kind == rrqs_pkg::EV_FINISHED), remaining_burst == 16'd0)
    `RRQS_ASSERT_NOW(a_arrived_no_wait,
        out_valid && (event_kind == rrqs_pkg::EV_ARRIVED), wait_ticks == 16'd0)

endmodule
`default_nettype wire
